@@ sv/rgb_3x3_kernel_filter_unit_macros.svh @@
// Assertion macros used by the filter top level.
// Each macro expects clk_i and rst_ni in the including module.
`ifndef RGB_3X3_KERNEL_FILTER_UNIT_MACROS_SVH
`define RGB_3X3_KERNEL_FILTER_UNIT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define RGB3K_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define RGB3K_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

@@ sv/rgb3k_pkg.sv @@
// Types, register codes and constants of the RGB 3x3 kernel filter.
// No dependencies; used by rgb3k_kernel and rgb_3x3_kernel_filter_unit.
`timescale 1ns / 1ps

package rgb3k_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 4096;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int WidthW    = 12;
  localparam int HeightW   = 13;
  localparam int PixW      = 24;
  localparam int AddrW     = 4;
  localparam int SumW      = 13;

  typedef logic [ColW-1:0]    col_t;
  typedef logic [RowW-1:0]    row_t;
  typedef logic [WidthW-1:0]  width_t;
  typedef logic [HeightW-1:0] height_t;
  typedef logic [PixW-1:0]    pixel_t;

  typedef pixel_t [2:0][2:0] window_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_pixel;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctrl_t;

  localparam logic [1:0] ModeBlur    = 2'd0;
  localparam logic [1:0] ModeSharpen = 2'd1;
  localparam logic [1:0] ModeEdge    = 2'd2;
  localparam logic [1:0] ModeEmboss  = 2'd3;

  localparam logic [1:0] RegMode   = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  localparam width_t  WidthReset  = 12'd640;
  localparam height_t HeightReset = 13'd480;
  localparam width_t  WidthMin    = 12'd3;
  localparam width_t  WidthMax    = width_t'(MaxWidth);
  localparam height_t HeightMin   = 13'd3;
  localparam height_t HeightMax   = height_t'(MaxHeight);

  // ceil(2^16 / 9): exact floor division for sums up to 9 * 255.
  localparam logic [12:0] NinthRecip = 13'd7282;

endpackage

@@ sv/rgb3k_kernel.sv @@
// Per-channel 3x3 kernel arithmetic: sum stage and divide/clamp output.
// Depends on rgb3k_pkg.
`timescale 1ns / 1ps

module rgb3k_kernel (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [1:0]            mode_i,
  input  rgb3k_pkg::stage_ctrl_t ctrl_i,
  input  rgb3k_pkg::window_t    win_i,
  output rgb3k_pkg::stage_ctrl_t ctrl_o,
  output rgb3k_pkg::out_item_t  res_o
);

  rgb3k_pkg::stage_ctrl_t ctrl_q;
  logic signed [rgb3k_pkg::SumW-1:0] sum_q [3];
  logic signed [rgb3k_pkg::SumW-1:0] sum_d [3];
  logic [7:0] chan_res [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    localparam int Lsb = 8 * (2 - ch);
    logic signed [rgb3k_pkg::SumW-1:0] tl, tc, tr, ml, mc, mr, bl, bc, br;
    logic [24:0] prod;

    assign tl = rgb3k_pkg::SumW'(win_i[0][0][Lsb +: 8]);
    assign tc = rgb3k_pkg::SumW'(win_i[0][1][Lsb +: 8]);
    assign tr = rgb3k_pkg::SumW'(win_i[0][2][Lsb +: 8]);
    assign ml = rgb3k_pkg::SumW'(win_i[1][0][Lsb +: 8]);
    assign mc = rgb3k_pkg::SumW'(win_i[1][1][Lsb +: 8]);
    assign mr = rgb3k_pkg::SumW'(win_i[1][2][Lsb +: 8]);
    assign bl = rgb3k_pkg::SumW'(win_i[2][0][Lsb +: 8]);
    assign bc = rgb3k_pkg::SumW'(win_i[2][1][Lsb +: 8]);
    assign br = rgb3k_pkg::SumW'(win_i[2][2][Lsb +: 8]);

    always_comb begin
      case (mode_i)
        rgb3k_pkg::ModeBlur: begin
          sum_d[ch] = tl + tc + tr + ml + mc + mr + bl + bc + br;
        end
        rgb3k_pkg::ModeSharpen: begin
          sum_d[ch] = (mc <<< 2) + mc - tc - ml - bc - mr;
        end
        rgb3k_pkg::ModeEdge: begin
          sum_d[ch] = tc + ml + bc + mr - (mc <<< 2);
        end
        default: begin
          sum_d[ch] = (br <<< 1) - (tl <<< 1) - tc - ml + bc + mr + mc;
        end
      endcase
    end

    assign prod = 25'(sum_q[ch][11:0]) * 25'(rgb3k_pkg::NinthRecip);

    always_comb begin
      if (mode_i == rgb3k_pkg::ModeBlur) begin
        chan_res[ch] = prod[23:16];
      end else if (sum_q[ch][rgb3k_pkg::SumW-1]) begin
        chan_res[ch] = 8'd0;
      end else if (sum_q[ch][11:8] != 4'd0) begin
        chan_res[ch] = 8'd255;
      end else begin
        chan_res[ch] = sum_q[ch][7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= sum_d[i];
      end
    end
  end

  assign ctrl_o = ctrl_q;
  assign res_o  = '{out_red:    chan_res[0],
                    out_green:  chan_res[1],
                    out_blue:   chan_res[2],
                    last_pixel: ctrl_q.last};

endmodule

@@ sv/rgb_3x3_kernel_filter_unit.sv @@
// Top level of the RGB 3x3 kernel filter: registers, row store, window, output skid.
// Depends on rgb3k_pkg, rgb3k_kernel and rgb_3x3_kernel_filter_unit_macros.svh.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+------------------------------
//   input    | in_valid_i / in_stall_o      | in_item_i (in_item_t)
//   output   | out_valid_o / out_stall_i    | out_item_o (out_item_t)
//   config   | psel/penable/pwrite/pready   | paddr, pwdata, prdata
//
// One pixel item is taken every cycle while in_stall_o is low; an interior
// pixel's result passes the s1, window, kernel sum and output registers in turn.
// The 2048 x 48 row store is read at the accept edge, written back as s1 advances.
// Reset clears positions, window and registers; the row store is not cleared.
// A stalled output fills a one-entry skid, after which in_stall_o rises.
`timescale 1ns / 1ps
`include "rgb_3x3_kernel_filter_unit_macros.svh"

module rgb_3x3_kernel_filter_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  rgb3k_pkg::in_item_t    in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rgb3k_pkg::out_item_t   out_item_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [rgb3k_pkg::AddrW-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [1:0]         mode_q;
  rgb3k_pkg::width_t  width_q;
  rgb3k_pkg::height_t height_q;
  rgb3k_pkg::width_t  w_eff;
  rgb3k_pkg::height_t h_eff;
  logic               cfg_wr;

  rgb3k_pkg::col_t col_q, col_d;
  rgb3k_pkg::row_t row_q, row_d;
  logic            col_end, row_end, emit;

  logic en, accept;

  logic [2*rgb3k_pkg::PixW-1:0] row_mem [rgb3k_pkg::MaxWidth];
  logic [2*rgb3k_pkg::PixW-1:0] rd_q;

  logic                   s1_valid_q;
  rgb3k_pkg::stage_ctrl_t s1_ctrl_q;
  rgb3k_pkg::col_t        s1_col_q;
  rgb3k_pkg::pixel_t      s1_px_q;

  rgb3k_pkg::window_t     win_q;
  rgb3k_pkg::stage_ctrl_t win_ctrl_q;

  rgb3k_pkg::stage_ctrl_t res_ctrl;
  rgb3k_pkg::out_item_t   res;

  logic                 out_valid_q, skid_valid_q;
  rgb3k_pkg::out_item_t out_q, skid_q;
  logic                 out_free;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= rgb3k_pkg::ModeBlur;
      width_q  <= rgb3k_pkg::WidthReset;
      height_q <= rgb3k_pkg::HeightReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        rgb3k_pkg::RegMode:   mode_q   <= pwdata[1:0];
        rgb3k_pkg::RegWidth:  width_q  <= pwdata[rgb3k_pkg::WidthW-1:0];
        rgb3k_pkg::RegHeight: height_q <= pwdata[rgb3k_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rgb3k_pkg::RegMode:   prdata = 32'(mode_q);
      rgb3k_pkg::RegWidth:  prdata = 32'(width_q);
      rgb3k_pkg::RegHeight: prdata = 32'(height_q);
      default:              prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (width_q < rgb3k_pkg::WidthMin) begin
      w_eff = rgb3k_pkg::WidthMin;
    end else if (width_q > rgb3k_pkg::WidthMax) begin
      w_eff = rgb3k_pkg::WidthMax;
    end else begin
      w_eff = width_q;
    end
    if (height_q < rgb3k_pkg::HeightMin) begin
      h_eff = rgb3k_pkg::HeightMin;
    end else if (height_q > rgb3k_pkg::HeightMax) begin
      h_eff = rgb3k_pkg::HeightMax;
    end else begin
      h_eff = height_q;
    end
  end

  // Raster position of the next input item.
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && en;

  assign col_end = (rgb3k_pkg::width_t'(col_q) + rgb3k_pkg::width_t'(1)) >= w_eff;
  assign row_end = (rgb3k_pkg::height_t'(row_q) + rgb3k_pkg::height_t'(1)) >= h_eff;
  assign emit    = (col_q >= rgb3k_pkg::col_t'(2)) && (row_q >= rgb3k_pkg::row_t'(2));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_end) begin
      col_d = '0;
      row_d = row_end ? '0 : row_q + rgb3k_pkg::row_t'(1);
    end else begin
      col_d = col_q + rgb3k_pkg::col_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_ctrl_q  <= '0;
      win_ctrl_q <= '0;
      win_q      <= '0;
    end else if (en) begin
      s1_valid_q <= accept;
      if (accept) begin
        col_q     <= col_d;
        row_q     <= row_d;
        s1_ctrl_q <= '{valid: emit, last: col_end && row_end};
      end
      win_ctrl_q <= '{valid: s1_valid_q && s1_ctrl_q.valid, last: s1_ctrl_q.last};
      if (s1_valid_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= rd_q[2*rgb3k_pkg::PixW-1:rgb3k_pkg::PixW];
        win_q[1][2] <= rd_q[rgb3k_pkg::PixW-1:0];
        win_q[2][2] <= s1_px_q;
      end
    end
  end

  // Row store: upper half is the older row, lower half the newer row.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q     <= row_mem[col_q];
      s1_col_q <= col_q;
      s1_px_q  <= {in_item_i.in_red, in_item_i.in_green, in_item_i.in_blue};
    end
    if (en && s1_valid_q) begin
      row_mem[s1_col_q] <= {rd_q[rgb3k_pkg::PixW-1:0], s1_px_q};
    end
  end

  rgb3k_kernel u_kernel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .mode_i (mode_q),
    .ctrl_i (win_ctrl_q),
    .win_i  (win_q),
    .ctrl_o (res_ctrl),
    .res_o  (res)
  );

  // Output register with a one-entry skid.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_ctrl.valid;
      end
    end else if (en && res_ctrl.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (en && res_ctrl.valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `RGB3K_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q,
                "skid holds an item while the output register is empty")
  `RGB3K_ASSERT(a_mem_no_overlap, !(accept && s1_valid_q) || (col_q != s1_col_q),
                "row store read and write-back hit the same entry")
  `RGB3K_ASSERT_NEXT(a_skid_fill, !skid_valid_q && out_valid_q && out_stall_i && res_ctrl.valid,
                     skid_valid_q, "result lost while the output was stalled")
  `RGB3K_ASSERT_NEXT(a_skid_drain, skid_valid_q && !out_stall_i, !skid_valid_q,
                     "skid did not drain into a free output register")

endmodule

@@ tb/tb_rgb_3x3_kernel_filter_unit.sv @@
// Self-checking testbench for rgb_3x3_kernel_filter_unit: streams RGB frames through the
// filter under random idling and backpressure and checks every filtered pixel in order.
// Depends on rgb3k_pkg and the filter RTL only.
`timescale 1ns / 1ps

module tb_rgb_3x3_kernel_filter_unit;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 8;
  localparam int RandomItems   = 370;
  localparam int BlurDivisor   = 9;

  typedef enum int {TexNoise, TexFlat, TexSaturated, TexChecker} texture_e;

  class filter_scoreboard;
    logic [1:0]           mode;
    rgb3k_pkg::width_t    width_reg;
    rgb3k_pkg::height_t   height_reg;
    rgb3k_pkg::pixel_t    older_row[rgb3k_pkg::MaxWidth];
    rgb3k_pkg::pixel_t    newer_row[rgb3k_pkg::MaxWidth];
    rgb3k_pkg::pixel_t    win[3][3];
    rgb3k_pkg::col_t      col;
    rgb3k_pkg::row_t      row;
    rgb3k_pkg::out_item_t expected_q[$];
    int unsigned          results_checked;
    int unsigned          err_count;

    function new();
      mode       = rgb3k_pkg::ModeBlur;
      width_reg  = rgb3k_pkg::WidthReset;
      height_reg = rgb3k_pkg::HeightReset;
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      foreach (win[r, c]) begin
        win[r][c] = '0;
      end
      col             = '0;
      row             = '0;
      results_checked = 0;
      err_count       = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        rgb3k_pkg::RegMode:   mode = value[1:0];
        rgb3k_pkg::RegWidth:  width_reg = value[rgb3k_pkg::WidthW-1:0];
        rgb3k_pkg::RegHeight: height_reg = value[rgb3k_pkg::HeightW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg < rgb3k_pkg::WidthMin) return 32'(rgb3k_pkg::WidthMin);
      if (width_reg > rgb3k_pkg::WidthMax) return 32'(rgb3k_pkg::WidthMax);
      return 32'(width_reg);
    endfunction

    function int unsigned eff_height();
      if (height_reg < rgb3k_pkg::HeightMin) return 32'(rgb3k_pkg::HeightMin);
      if (height_reg > rgb3k_pkg::HeightMax) return 32'(rgb3k_pkg::HeightMax);
      return 32'(height_reg);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function bit at_frame_start();
      return (col == '0) && (row == '0);
    endfunction

    function int clamp_byte(int v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
    endfunction

    function int chan(rgb3k_pkg::pixel_t px, int unsigned sh);
      return int'(px[sh +: 8]);
    endfunction

    function logic [7:0] kernel_value(int unsigned sh);
      int tl, tc, tr, ml, mc, mr, bl, bc, br, s;
      tl = chan(win[0][0], sh);
      tc = chan(win[0][1], sh);
      tr = chan(win[0][2], sh);
      ml = chan(win[1][0], sh);
      mc = chan(win[1][1], sh);
      mr = chan(win[1][2], sh);
      bl = chan(win[2][0], sh);
      bc = chan(win[2][1], sh);
      br = chan(win[2][2], sh);
      s  = 0;
      case (mode)
        rgb3k_pkg::ModeBlur:    s = (tl + tc + tr + ml + mc + mr + bl + bc + br) / BlurDivisor;
        rgb3k_pkg::ModeSharpen: s = 5 * mc - tc - ml - bc - mr;
        rgb3k_pkg::ModeEdge:    s = tc + ml + bc + mr - 4 * mc;
        rgb3k_pkg::ModeEmboss:  s = -2 * tl + 2 * br - tc - ml + bc + mr + mc;
        default: ;
      endcase
      return 8'(clamp_byte(s));
    endfunction

    function void note_pixel(rgb3k_pkg::in_item_t item);
      int unsigned          w, h;
      rgb3k_pkg::pixel_t    px, up1, up2;
      rgb3k_pkg::out_item_t res;
      w   = eff_width();
      h   = eff_height();
      px  = {item.in_red, item.in_green, item.in_blue};
      up2 = older_row[col];
      up1 = newer_row[col];
      older_row[col] = up1;
      newer_row[col] = px;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = up2;
      win[1][2] = up1;
      win[2][2] = px;
      if (col >= rgb3k_pkg::col_t'(2) && row >= rgb3k_pkg::row_t'(2)) begin
        res.out_red    = kernel_value(16);
        res.out_green  = kernel_value(8);
        res.out_blue   = kernel_value(0);
        res.last_pixel = (32'(col) + 1 >= w) && (32'(row) + 1 >= h);
        expected_q.push_back(res);
      end
      if (32'(col) + 1 >= w) begin
        col = '0;
        row = (32'(row) + 1 >= h) ? '0 : row + rgb3k_pkg::row_t'(1);
      end else begin
        col = col + rgb3k_pkg::col_t'(1);
      end
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: result %0d: %s", $time, results_checked, msg);
      err_count++;
    endtask

    task check_pixel(rgb3k_pkg::out_item_t got);
      rgb3k_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.out_red !== want.out_red) begin
        report_mismatch($sformatf("red %0d, expected %0d", got.out_red, want.out_red));
      end
      if (got.out_green !== want.out_green) begin
        report_mismatch($sformatf("green %0d, expected %0d", got.out_green, want.out_green));
      end
      if (got.out_blue !== want.out_blue) begin
        report_mismatch($sformatf("blue %0d, expected %0d", got.out_blue, want.out_blue));
      end
      if (got.last_pixel !== want.last_pixel) begin
        report_mismatch($sformatf("last %b, expected %b", got.last_pixel, want.last_pixel));
      end
      results_checked++;
    endtask
  endclass

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  rgb3k_pkg::in_item_t         in_item_i   = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  rgb3k_pkg::out_item_t        out_item_o;
  logic                        psel        = 1'b0;
  logic                        penable     = 1'b0;
  logic                        pwrite      = 1'b0;
  logic [rgb3k_pkg::AddrW-1:0] paddr       = '0;
  logic [31:0]                 pwdata      = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  filter_scoreboard sb = new();

  bit                  src_gaps    = 1'b1;
  bit                  sink_gaps   = 1'b1;
  bit                  hold_req    = 1'b0;
  bit                  hold_done   = 1'b0;
  texture_e            texture     = TexChecker;
  rgb3k_pkg::in_item_t flat_base   = '0;
  int unsigned         pixels_sent = 0;
  int unsigned         idle_cycles = 0;

  rgb_3x3_kernel_filter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic rgb3k_pkg::in_item_t make_pixel();
    rgb3k_pkg::in_item_t item;
    bit                  lit;
    item = 24'($urandom);
    lit  = sb.col[0] ^ sb.row[0];
    case (texture)
      TexFlat: begin
        item.in_red   = flat_base.in_red + 8'($urandom_range(0, 15));
        item.in_green = flat_base.in_green + 8'($urandom_range(0, 15));
        item.in_blue  = flat_base.in_blue + 8'($urandom_range(0, 15));
      end
      TexSaturated: begin
        item.in_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        item.in_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        item.in_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      TexChecker: begin
        item.in_red   = lit ? 8'hFF : 8'h00;
        item.in_green = lit ? 8'h00 : 8'hFF;
      end
      default: ;
    endcase
    return item;
  endfunction

  task automatic send_pixel(input rgb3k_pkg::in_item_t item);
    if (src_gaps && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(item);
    pixels_sent++;
  endtask

  task automatic send_pixels(input int unsigned count);
    repeat (count) send_pixel(make_pixel());
  endtask

  task automatic finish_frame();
    do send_pixel(make_pixel()); while (!sb.at_frame_start());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_pixel(out_item_o);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall_i <= sink_gaps && ($urandom_range(99) < 25);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]  sweep[3];
    int unsigned random_start;
    sweep = '{rgb3k_pkg::ModeSharpen, rgb3k_pkg::ModeEdge, rgb3k_pkg::ModeEmboss};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A width below the minimum acts as three columns; the kernel changes between rows.
    write_register(rgb3k_pkg::RegWidth, 32'd1);
    write_register(rgb3k_pkg::RegHeight, 32'd6);
    write_register(rgb3k_pkg::RegMode, 32'(rgb3k_pkg::ModeBlur));
    send_pixels(9);
    foreach (sweep[i]) begin
      drain();
      write_register(rgb3k_pkg::RegMode, 32'(sweep[i]));
      send_pixels(3);
    end
    drain();

    random_start = pixels_sent;
    while (pixels_sent - random_start < RandomItems) begin
      texture   = texture_e'($urandom_range(0, 3));
      flat_base = 24'($urandom);
      write_register(rgb3k_pkg::RegMode, 32'($urandom_range(0, 3)));
      write_register(rgb3k_pkg::RegWidth, ($urandom_range(0, 4) == 0)
                                          ? 32'($urandom_range(0, 2))
                                          : 32'($urandom_range(3, 12)));
      write_register(rgb3k_pkg::RegHeight, ($urandom_range(0, 4) == 0)
                                           ? 32'($urandom_range(0, 2))
                                           : 32'($urandom_range(3, 8)));
      if ($urandom_range(0, 2) == 0) begin
        // Kernel and height change while a frame is open; the row may wrap early.
        send_pixels(sb.eff_width() * $urandom_range(1, 4));
        drain();
        write_register(rgb3k_pkg::RegMode, 32'($urandom_range(0, 3)));
        write_register(rgb3k_pkg::RegHeight, 32'($urandom_range(0, 8)));
      end
      repeat ($urandom_range(1, 2)) finish_frame();
      drain();
    end

    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    texture   = texture_e'($urandom_range(0, 3));
    write_register(rgb3k_pkg::RegMode, 32'($urandom_range(0, 3)));
    write_register(rgb3k_pkg::RegWidth, 32'd12);
    write_register(rgb3k_pkg::RegHeight, 32'd8);
    finish_frame();
    drain();

    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    texture   = texture_e'($urandom_range(0, 3));
    write_register(rgb3k_pkg::RegMode, 32'($urandom_range(0, 3)));
    write_register(rgb3k_pkg::RegWidth, 32'd8);
    write_register(rgb3k_pkg::RegHeight, 32'd6);
    send_pixels(16);
    hold_req = 1'b1;
    finish_frame();
    drain();

    if (sb.err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
